// ----- rtl/crc32c_pkg.sv -----
`default_nettype none

package crc32c_pkg;

    typedef logic [31:0] poly_t;

    localparam int TABLE_SIZE = 31;
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] BYTE_SHIFT = 5'd3;
    localparam logic [IDX_W-1:0] TABLE_LAST = 5'd30;

    localparam poly_t CASTAGNOLI = 32'h82F6_3B78;
    localparam poly_t IDENTITY_POLY = 32'h8000_0000;
    localparam poly_t ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_EXTEND = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_XOR    = 2'd3;

    localparam poly_t POW_TABLE [0:TABLE_SIZE-1] = '{
        32'h40000000, 32'h20000000, 32'h08000000, 32'h00800000, 32'h00008000,
        32'h82f63b78, 32'h6ea2d55c, 32'h18b8ea18, 32'h510ac59a, 32'hb82be955,
        32'hb8fdb1e7, 32'h88e56f72, 32'h74c360a4, 32'he4172b16, 32'h0d65762a,
        32'h35d73a62, 32'h28461564, 32'hbf455269, 32'he2ea32dc, 32'hfe7740e6,
        32'hf946610b, 32'h3c204f8f, 32'h538586e3, 32'h59726915, 32'h734d5309,
        32'hbc1ac763, 32'h7d0722cc, 32'hd289cabe, 32'he94ca9bc, 32'h05b74f3f,
        32'ha51e1f42
    };

    localparam poly_t INV_TABLE [0:TABLE_SIZE-1] = '{
        32'h05ec76f1, 32'h0bd8ede2, 32'h2f63b788, 32'hfde39562, 32'hbef0965e,
        32'hd610d67e, 32'he67cce65, 32'ha268b79e, 32'h134fb088, 32'h32998d96,
        32'hcedac2cc, 32'h70118575, 32'h0e004a40, 32'ha7864c8b, 32'hbc7be916,
        32'h10ba2894, 32'h6077197b, 32'h98448e4e, 32'h8baf845d, 32'he93e07fc,
        32'hf58027d7, 32'h5e2b422d, 32'h9db2851c, 32'h9270ed25, 32'h5984e7b3,
        32'h7af026f1, 32'he0f4116b, 32'hace8a6b0, 32'h9e09f006, 32'h6a60ea71,
        32'h4fd04875
    };

    // Carry-less product of two reflected polynomials, reduced modulo the
    // Castagnoli polynomial.
    function automatic poly_t poly_mul(input poly_t a, input poly_t b);
        poly_t acc;
        poly_t bb;
        acc = '0;
        bb = b;
        for (int i = 0; i < 32; i++) begin
            if (a[31-i]) begin
                acc = acc ^ bb;
            end
            bb = bb[0] ? ((bb >> 1) ^ CASTAGNOLI) : (bb >> 1);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/crc32c_combine_and_extend_unit.sv -----
// CRC-32C combine and extend unit.
// Input channel (s_valid/s_ready) carries an opcode, two finished CRCs and a
// byte count; the output channel (m_valid/m_ready) returns one CRC per beat.
// Opcodes: append CRC B of a following block to CRC A, extend by zero bytes,
// remove zero bytes, and the xor-combine rule.
// The unit walks the low bits of the byte count, one bit per cycle, through a
// single shared modulo-polynomial multiplier fed from constant power tables,
// then performs the final multiply in a final step.
// s_ready is high only while the sequencer is idle, so a new beat can be
// taken only once the previous beat has left its final step.
// The result sits in an output register; once it is taken, or whilst it is
// still waiting, the next input beat can be accepted. If the receiver stalls
// with a result pending and a second result is ready, the sequencer holds in
// its final step until the output register frees up.
// A synchronous active-low reset returns the sequencer to idle and clears
// m_valid; any beat in flight or waiting on the output is discarded.
`default_nettype none

module crc32c_combine_and_extend_unit
    import crc32c_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [31:0] s_crc_first,
    input  wire logic [31:0] s_crc_second,
    input  wire logic [31:0] s_byte_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_crc_out
);

    localparam int WALK = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam int CNT_W = $clog2(WALK);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WALK - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       op_reg, op_next;
    poly_t            a_reg, a_next;
    poly_t            b_reg, b_next;
    logic [31:0]      n_reg, n_next;
    poly_t            f_reg, f_next;
    logic             m_valid_reg, m_valid_next;
    poly_t            m_crc_out_reg, m_crc_out_next;

    poly_t mul_a, mul_b, mul_p;
    logic  out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_crc_out = m_crc_out_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign mul_p     = poly_mul(mul_a, mul_b);

    always_comb begin
        if (state_reg == ST_WALK) begin
            mul_a = (op_reg == OP_REMOVE) ? INV_TABLE[idx_reg] : POW_TABLE[idx_reg];
            mul_b = f_reg;
        end else if (op_reg == OP_XOR) begin
            mul_a = ALL_ONES;
            mul_b = f_reg;
        end else begin
            mul_a = f_reg;
            mul_b = (op_reg == OP_APPEND) ? a_reg : ~a_reg;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        f_next         = f_reg;
        m_valid_next   = m_valid_reg;
        m_crc_out_next = m_crc_out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    a_next     = s_crc_first;
                    b_next     = s_crc_second;
                    n_next     = s_byte_count;
                    f_next     = IDENTITY_POLY;
                    idx_next   = BYTE_SHIFT;
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (n_reg[0]) begin
                    f_next = mul_p;
                end
                n_next   = n_reg >> 1;
                idx_next = (idx_reg == TABLE_LAST) ? '0 : idx_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    unique case (op_reg)
                        OP_APPEND: m_crc_out_next = mul_p ^ b_reg;
                        OP_XOR:    m_crc_out_next = a_reg ^ b_reg ^ ~mul_p;
                        default:   m_crc_out_next = ~mul_p;
                    endcase
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        n_reg         <= n_next;
        f_reg         <= f_next;
        m_crc_out_reg <= m_crc_out_next;
    end

`ifndef SYNTH
    a_result_from_final: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINAL))
        else $error("result appeared without a final step");

    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_WALK && f_reg == IDENTITY_POLY
            && idx_reg == BYTE_SHIFT && cnt_reg == '0))
        else $error("walk did not start cleanly");

    a_index_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (idx_reg <= TABLE_LAST))
        else $error("power table index out of range");

    a_final_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL && m_valid && !m_ready) |=> (state_reg == ST_FINAL))
        else $error("final step left while output was stalled");
`endif

endmodule

`default_nettype wire
